@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the register ALU block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that cond at one edge implies prop at the next edge
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ design/mra_pkg.sv @@
// ----------------------------------------------------------------------------
// mra_pkg
// Types and constants of the register-type ALU with its register file.
// ----------------------------------------------------------------------------
`default_nettype none

package mra_pkg;

   localparam int REG_COUNT = 32;
   localparam int ADDR_W    = $clog2(REG_COUNT);

   localparam int OP_W    = 4;
   localparam int IDX_W   = 5;
   localparam int DATA_W  = 64;
   localparam int HALF_W  = 32;

   // request fields, lowest bit up
   localparam int REQ_OP_LO   = 0;
   localparam int REQ_SRCA_LO = REQ_OP_LO + OP_W;
   localparam int REQ_SRCB_LO = REQ_SRCA_LO + IDX_W;
   localparam int REQ_DEST_LO = REQ_SRCB_LO + IDX_W;
   localparam int REQ_WV_LO   = REQ_DEST_LO + IDX_W;
   localparam int REQ_BITS    = REQ_WV_LO + DATA_W;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;

   // response fields, lowest bit up
   localparam int RSP_RES_LO  = 0;
   localparam int RSP_DEST_LO = RSP_RES_LO + DATA_W;
   localparam int RSP_WR_BIT  = RSP_DEST_LO + IDX_W;
   localparam int RSP_BITS    = RSP_WR_BIT + 1;
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_ADD32 = 4'd0,
      OP_DADD  = 4'd1,
      OP_SUB32 = 4'd2,
      OP_DSUB  = 4'd3,
      OP_AND   = 4'd4,
      OP_OR    = 4'd5,
      OP_XOR   = 4'd6,
      OP_NOR   = 4'd7,
      OP_SLT   = 4'd8,
      OP_SLTU  = 4'd9,
      OP_WRITE = 4'd10
   } op_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } wr_port_type;

   // true when the index names a real register other than register 0
   function automatic logic idx_in_file(input logic [IDX_W-1:0] idx);
      logic ok;
      ok = (idx != '0) && (int'(idx) < REG_COUNT);
      return ok;
   endfunction

endpackage

`default_nettype wire

@@ design/mra_regfile.sv @@
// ----------------------------------------------------------------------------
// mra_regfile
// Register file with two registered read ports, one write port, per-entry
// valid bits cleared by reset and a bypass of a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module mra_regfile (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [mra_pkg::IDX_W-1:0]   rd_addr_a,
   input  wire logic [mra_pkg::IDX_W-1:0]   rd_addr_b,
   input  wire mra_pkg::wr_port_type        wr_port,
   output logic      [mra_pkg::DATA_W-1:0]  rd_data_a,
   output logic      [mra_pkg::DATA_W-1:0]  rd_data_b
);

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_MEM  = 2'd1,
      SEL_BYP  = 2'd2
   } src_sel_type;

   logic [mra_pkg::DATA_W-1:0] mem [0:mra_pkg::REG_COUNT-1];
   logic [mra_pkg::REG_COUNT-1:0] valid_ff;
   logic [mra_pkg::DATA_W-1:0] mem_a_ff;
   logic [mra_pkg::DATA_W-1:0] mem_b_ff;
   logic [mra_pkg::DATA_W-1:0] byp_ff;
   src_sel_type sel_a_ff;
   src_sel_type sel_a_in;
   src_sel_type sel_b_ff;
   src_sel_type sel_b_in;

   function automatic src_sel_type pick_src(
      input logic [mra_pkg::IDX_W-1:0]    idx,
      input mra_pkg::wr_port_type         wp,
      input logic [mra_pkg::REG_COUNT-1:0] vld
   );
      src_sel_type sel;
      if (!mra_pkg::idx_in_file(idx)) begin
         sel = SEL_ZERO;
      end else if (wp.en && (wp.addr == idx)) begin
         sel = SEL_BYP;
      end else if (vld[idx[mra_pkg::ADDR_W-1:0]]) begin
         sel = SEL_MEM;
      end else begin
         sel = SEL_ZERO;
      end
      return sel;
   endfunction

   assign sel_a_in = pick_src(rd_addr_a, wr_port, valid_ff);
   assign sel_b_in = pick_src(rd_addr_b, wr_port, valid_ff);

   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         mem[wr_port.addr[mra_pkg::ADDR_W-1:0]] <= wr_port.data;
      end
      if (rd_en) begin
         mem_a_ff <= mem[rd_addr_a[mra_pkg::ADDR_W-1:0]];
         mem_b_ff <= mem[rd_addr_b[mra_pkg::ADDR_W-1:0]];
         byp_ff   <= wr_port.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         sel_a_ff <= SEL_ZERO;
         sel_b_ff <= SEL_ZERO;
      end else begin
         if (wr_port.en) begin
            valid_ff[wr_port.addr[mra_pkg::ADDR_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            sel_a_ff <= sel_a_in;
            sel_b_ff <= sel_b_in;
         end
      end
   end

   always_comb begin
      case (sel_a_ff)
         SEL_MEM: rd_data_a = mem_a_ff;
         SEL_BYP: rd_data_a = byp_ff;
         default: rd_data_a = '0;
      endcase
      case (sel_b_ff)
         SEL_MEM: rd_data_b = mem_b_ff;
         SEL_BYP: rd_data_b = byp_ff;
         default: rd_data_b = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ design/mra_alu.sv @@
// ----------------------------------------------------------------------------
// mra_alu
// Operation decode and datapath: 32-bit and 64-bit add and subtract, logic
// operations, set-less-than and pass-through of an outside value.
// ----------------------------------------------------------------------------
`default_nettype none

module mra_alu (
   input  wire mra_pkg::op_type             op,
   input  wire logic [mra_pkg::DATA_W-1:0]  opnd_a,
   input  wire logic [mra_pkg::DATA_W-1:0]  opnd_b,
   input  wire logic [mra_pkg::DATA_W-1:0]  write_value,
   input  wire logic [mra_pkg::IDX_W-1:0]   dest,
   output logic      [mra_pkg::DATA_W-1:0]  result,
   output logic                             written
);

   logic [mra_pkg::HALF_W-1:0] sum32;
   logic [mra_pkg::HALF_W-1:0] diff32;
   logic                       op_ok;

   assign sum32  = opnd_a[mra_pkg::HALF_W-1:0] + opnd_b[mra_pkg::HALF_W-1:0];
   assign diff32 = opnd_a[mra_pkg::HALF_W-1:0] - opnd_b[mra_pkg::HALF_W-1:0];

   always_comb begin
      op_ok = 1'b1;
      unique case (op)
         mra_pkg::OP_ADD32:
            result = {{mra_pkg::HALF_W{sum32[mra_pkg::HALF_W-1]}}, sum32};
         mra_pkg::OP_DADD:  result = opnd_a + opnd_b;
         mra_pkg::OP_SUB32:
            result = {{mra_pkg::HALF_W{diff32[mra_pkg::HALF_W-1]}}, diff32};
         mra_pkg::OP_DSUB:  result = opnd_a - opnd_b;
         mra_pkg::OP_AND:   result = opnd_a & opnd_b;
         mra_pkg::OP_OR:    result = opnd_a | opnd_b;
         mra_pkg::OP_XOR:   result = opnd_a ^ opnd_b;
         mra_pkg::OP_NOR:   result = ~(opnd_a | opnd_b);
         mra_pkg::OP_SLT:
            result = {{(mra_pkg::DATA_W-1){1'b0}}, ($signed(opnd_a) < $signed(opnd_b))};
         mra_pkg::OP_SLTU:
            result = {{(mra_pkg::DATA_W-1){1'b0}}, (opnd_a < opnd_b)};
         mra_pkg::OP_WRITE: result = write_value;
         default: begin
            result = '0;
            op_ok  = 1'b0;
         end
      endcase
   end

   assign written = op_ok && mra_pkg::idx_in_file(dest);

endmodule

`default_nettype wire

@@ design/mips64_register_alu_core.sv @@
// ----------------------------------------------------------------------------
// mips64_register_alu_core: register-type ALU with its own register file
// Pipeline: a request goes into the register file read port register and the input register,
// then into the response register. Throughput: 1 transaction per cycle while the response
// is not held by rsp_tready low, dependent items back to back.
// Reset: clears all pipeline valids and marks every register as zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mips64_register_alu_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // operation[3:0], src_a[8:4], src_b[13:9], dest[18:14], write_value[82:19]
   input  wire logic [mra_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // result_value[63:0], dest_index[68:64], written[69]
   output logic      [mra_pkg::RSP_W-1:0]   rsp_tdata
);

   logic req_accept;
   logic advance;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   mra_pkg::op_type            s1_op_ff;
   logic [mra_pkg::IDX_W-1:0]  s1_dest_ff;
   logic [mra_pkg::DATA_W-1:0] s1_wv_ff;

   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [mra_pkg::DATA_W-1:0] out_result_ff;
   logic [mra_pkg::IDX_W-1:0]  out_dest_ff;
   logic                       out_written_ff;

   logic [mra_pkg::DATA_W-1:0] opnd_a;
   logic [mra_pkg::DATA_W-1:0] opnd_b;
   logic [mra_pkg::DATA_W-1:0] alu_result;
   logic                       alu_written;
   mra_pkg::wr_port_type       wr_port;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign wr_port.en   = advance && alu_written;
   assign wr_port.addr = s1_dest_ff;
   assign wr_port.data = alu_result;

   mra_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr_a (req_tdata[mra_pkg::REQ_SRCA_LO +: mra_pkg::IDX_W]),
      .rd_addr_b (req_tdata[mra_pkg::REQ_SRCB_LO +: mra_pkg::IDX_W]),
      .wr_port   (wr_port),
      .rd_data_a (opnd_a),
      .rd_data_b (opnd_b)
   );

   mra_alu u_alu (
      .op          (s1_op_ff),
      .opnd_a      (opnd_a),
      .opnd_b      (opnd_b),
      .write_value (s1_wv_ff),
      .dest        (s1_dest_ff),
      .result      (alu_result),
      .written     (alu_written)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= mra_pkg::op_type'(req_tdata[mra_pkg::REQ_OP_LO +: mra_pkg::OP_W]);
         s1_dest_ff <= req_tdata[mra_pkg::REQ_DEST_LO +: mra_pkg::IDX_W];
         s1_wv_ff   <= req_tdata[mra_pkg::REQ_WV_LO +: mra_pkg::DATA_W];
      end
      if (advance) begin
         out_result_ff  <= alu_result;
         out_dest_ff    <= s1_dest_ff;
         out_written_ff <= alu_written;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(mra_pkg::RSP_W - mra_pkg::RSP_BITS){1'b0}},
                        out_written_ff, out_dest_ff, out_result_ff};

   `ASSERT_CLK(a_no_write_reg0, clock, reset,
      !(rsp_tvalid && out_written_ff && (out_dest_ff == '0)),
      "register 0 reported as written")
   `ASSERT_CLK(a_write_known_op, clock, reset,
      !wr_port.en || (s1_op_ff <= mra_pkg::OP_WRITE),
      "register file written by an undefined operation")
   `ASSERT_NEXT(a_advance_fills_out, clock, reset, advance,
      out_valid_ff && (out_dest_ff == $past(s1_dest_ff)),
      "advanced item missing from response register")
   `ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_dest_ff) && $stable(s1_wv_ff),
      "stalled item lost from input register")

endmodule

`default_nettype wire
